FILE: hdl/wavhv_pkg.sv
// Shared types, constants and the tag lookup for the WAV header checker.
`timescale 1ns / 1ps

package wavhv_pkg;

    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] HDR_LEN = 6'd44;
    localparam logic [31:0] FMT_PCM_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM = 16'd1;
    localparam logic [32:0] RIFF_OVERHEAD = 33'd36;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_RIFF     = 4'd1,
        ST_WAVE     = 4'd2,
        ST_FMT_TAG  = 4'd3,
        ST_FMT_SIZE = 4'd4,
        ST_FORMAT   = 4'd5,
        ST_CHANNELS = 4'd6,
        ST_BYTERATE = 4'd7,
        ST_BITS     = 4'd8,
        ST_ALIGN    = 4'd9,
        ST_DATA_TAG = 4'd10,
        ST_SHORT    = 4'd11,
        ST_BAD_SIZE = 4'd12,
        ST_TRUNC    = 4'd13
    } status_t;

    typedef struct packed {
        logic       is_tag;
        logic [7:0] expected;
        status_t    code;
    } tag_t;

    // Expected character at each tag position of the canonical header.
    function automatic tag_t tag_lookup(input logic [POS_W-1:0] pos);
        tag_t t;
        t = '{is_tag: 1'b1, expected: 8'd0, code: ST_OK};
        case (pos)
            6'd0:  begin t.expected = 8'd82;  t.code = ST_RIFF; end
            6'd1:  begin t.expected = 8'd73;  t.code = ST_RIFF; end
            6'd2:  begin t.expected = 8'd70;  t.code = ST_RIFF; end
            6'd3:  begin t.expected = 8'd70;  t.code = ST_RIFF; end
            6'd8:  begin t.expected = 8'd87;  t.code = ST_WAVE; end
            6'd9:  begin t.expected = 8'd65;  t.code = ST_WAVE; end
            6'd10: begin t.expected = 8'd86;  t.code = ST_WAVE; end
            6'd11: begin t.expected = 8'd69;  t.code = ST_WAVE; end
            6'd12: begin t.expected = 8'd102; t.code = ST_FMT_TAG; end
            6'd13: begin t.expected = 8'd109; t.code = ST_FMT_TAG; end
            6'd14: begin t.expected = 8'd116; t.code = ST_FMT_TAG; end
            6'd15: begin t.expected = 8'd32;  t.code = ST_FMT_TAG; end
            6'd36: begin t.expected = 8'd100; t.code = ST_DATA_TAG; end
            6'd37: begin t.expected = 8'd97;  t.code = ST_DATA_TAG; end
            6'd38: begin t.expected = 8'd116; t.code = ST_DATA_TAG; end
            6'd39: begin t.expected = 8'd97;  t.code = ST_DATA_TAG; end
            default: t.is_tag = 1'b0;
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/wav_header_validator_core.sv
// Streaming checker for the canonical 44-byte RIFF/WAVE PCM file header.
//
//   channel | ports            | direction | content
//   s_      | valid/ready      | in        | one file byte and its last-byte flag
//   m_      | valid/ready      | out       | status and header fields of one file
//
// A word is taken into an input register and checked once the result register is free or
// being emptied; one word is accepted every cycle while the result register is not stalled.
// A result passes from the input register into the result register before it is valid.
// A stalled result register holds the input register, which then lowers s_ready.
// Reset (aresetn low, synchronous) clears the parser as at the start of a file.
`timescale 1ns / 1ps

module wav_header_validator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [31:0] m_file_size,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_sample_rate,
    output logic [31:0] m_byte_rate,
    output logic [15:0] m_block_align,
    output logic [15:0] m_sample_bits,
    output logic [31:0] m_data_size,
    output logic [31:0] m_data_count
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_last_reg;
    logic                          proc_fire;

    logic [wavhv_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                          stopped_reg;
    logic [31:0]                   riff_reg, riff_next;
    logic [31:0]                   fmt_len_reg, fmt_len_next;
    logic [15:0]                   format_reg, format_next;
    logic [15:0]                   chan_reg, chan_next;
    logic [31:0]                   rate_reg, rate_next;
    logic [31:0]                   bps_reg, bps_next;
    logic [15:0]                   align_reg, align_next;
    logic [15:0]                   bits_reg, bits_next;
    logic [31:0]                   chunk_reg, chunk_next;
    logic [31:0]                   count_reg, count_next;
    logic [39:0]                   prod_lo_reg;
    logic [39:0]                   prod_part;
    logic [47:0]                   prod_full;
    logic [16:0]                   align_want;

    wavhv_pkg::tag_t               tag;
    logic [1:0]                    lane;
    logic                          err;
    wavhv_pkg::status_t            err_code;
    wavhv_pkg::status_t            res_code;
    logic                          emit;

    logic                          out_valid_reg;
    wavhv_pkg::status_t            out_status_reg;
    logic [31:0]                   out_file_size_reg;
    logic [15:0]                   out_chan_reg;
    logic [31:0]                   out_rate_reg;
    logic [31:0]                   out_bps_reg;
    logic [15:0]                   out_align_reg;
    logic [15:0]                   out_bits_reg;
    logic [31:0]                   out_chunk_reg;
    logic [31:0]                   out_count_reg;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_last_reg <= s_last_byte;
        end
    end

    assign tag       = wavhv_pkg::tag_lookup(pos_reg);
    assign lane      = pos_reg[1:0];
    assign prod_part = {8'd0, rate_reg} * {32'd0, in_byte_reg};
    assign prod_full = {8'd0, prod_lo_reg} + {prod_part, 8'd0};

    always_comb begin
        pos_next     = pos_reg;
        riff_next    = riff_reg;
        fmt_len_next = fmt_len_reg;
        format_next  = format_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        bps_next     = bps_reg;
        align_next   = align_reg;
        bits_next    = bits_reg;
        chunk_next   = chunk_reg;
        count_next   = count_reg;
        err          = 1'b0;
        err_code     = wavhv_pkg::ST_OK;
        align_want   = '0;

        if (pos_reg < wavhv_pkg::HDR_LEN) begin
            pos_next = pos_reg + 6'd1;
            if (tag.is_tag && in_byte_reg != tag.expected) begin
                err      = 1'b1;
                err_code = tag.code;
            end
            case (pos_reg) inside
                [6'd4:6'd7]:   riff_next[8*lane +: 8]    = in_byte_reg;
                [6'd16:6'd19]: fmt_len_next[8*lane +: 8] = in_byte_reg;
                [6'd20:6'd21]: format_next[8*lane[0] +: 8] = in_byte_reg;
                [6'd22:6'd23]: chan_next[8*lane[0] +: 8]   = in_byte_reg;
                [6'd24:6'd27]: rate_next[8*lane +: 8]    = in_byte_reg;
                [6'd28:6'd31]: bps_next[8*lane +: 8]     = in_byte_reg;
                [6'd32:6'd33]: align_next[8*lane[0] +: 8]  = in_byte_reg;
                [6'd34:6'd35]: bits_next[8*lane[0] +: 8]   = in_byte_reg;
                [6'd40:6'd43]: chunk_next[8*lane +: 8]   = in_byte_reg;
                default: ;
            endcase

            align_want = (bits_next == 16'd16) ? {chan_reg, 1'b0} : {1'b0, chan_reg};
            case (pos_reg)
                6'd19: begin
                    if (fmt_len_next != wavhv_pkg::FMT_PCM_LEN) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_FMT_SIZE;
                    end
                end
                6'd21: begin
                    if (format_next != wavhv_pkg::FMT_PCM) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_FORMAT;
                    end
                end
                6'd23: begin
                    if (chan_next != 16'd1 && chan_next != 16'd2) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_CHANNELS;
                    end
                end
                6'd33: begin
                    if (prod_full != {16'd0, bps_reg}) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_BYTERATE;
                    end
                end
                6'd35: begin
                    if (bits_next != 16'd8 && bits_next != 16'd16) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_BITS;
                    end else if ({1'b0, align_reg} != align_want) begin
                        err      = 1'b1;
                        err_code = wavhv_pkg::ST_ALIGN;
                    end
                end
                default: ;
            endcase
        end else if (count_reg != 32'hFFFF_FFFF) begin
            count_next = count_reg + 32'd1;
        end

        if (err) begin
            res_code = err_code;
        end else if (pos_next < wavhv_pkg::HDR_LEN) begin
            res_code = wavhv_pkg::ST_TRUNC;
        end else if (count_next < chunk_next) begin
            res_code = wavhv_pkg::ST_SHORT;
        end else if ({1'b0, count_next} + wavhv_pkg::RIFF_OVERHEAD > {1'b0, riff_next}) begin
            res_code = wavhv_pkg::ST_BAD_SIZE;
        end else begin
            res_code = wavhv_pkg::ST_OK;
        end
    end

    assign emit = proc_fire && !stopped_reg && (err || in_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || (proc_fire && in_last_reg)) begin
            pos_reg     <= '0;
            stopped_reg <= 1'b0;
            riff_reg    <= '0;
            fmt_len_reg <= '0;
            format_reg  <= '0;
            chan_reg    <= '0;
            rate_reg    <= '0;
            bps_reg     <= '0;
            align_reg   <= '0;
            bits_reg    <= '0;
            chunk_reg   <= '0;
            count_reg   <= '0;
        end else if (proc_fire && !stopped_reg) begin
            pos_reg     <= pos_next;
            stopped_reg <= err;
            riff_reg    <= riff_next;
            fmt_len_reg <= fmt_len_next;
            format_reg  <= format_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            bps_reg     <= bps_next;
            align_reg   <= align_next;
            bits_reg    <= bits_next;
            chunk_reg   <= chunk_next;
            count_reg   <= count_next;
        end
    end

    // The low-byte partial product is kept so the rate check needs only a 32-by-8-bit multiplier.
    always_ff @(posedge aclk) begin
        if (proc_fire && pos_reg == 6'd32) begin
            prod_lo_reg <= prod_part;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_status_reg    <= res_code;
            out_file_size_reg <= riff_next;
            out_chan_reg      <= chan_next;
            out_rate_reg      <= rate_next;
            out_bps_reg       <= bps_next;
            out_align_reg     <= align_next;
            out_bits_reg      <= bits_next;
            out_chunk_reg     <= chunk_next;
            out_count_reg     <= count_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_file_size     = out_file_size_reg;
    assign m_channel_count = out_chan_reg;
    assign m_sample_rate   = out_rate_reg;
    assign m_byte_rate     = out_bps_reg;
    assign m_block_align   = out_align_reg;
    assign m_sample_bits   = out_bits_reg;
    assign m_data_size     = out_chunk_reg;
    assign m_data_count    = out_count_reg;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= wavhv_pkg::HDR_LEN)
        else $error("Header position ran past the header length.");

    a_stop_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> pos_reg != '0)
        else $error("Parser stopped without having consumed a header word.");

    a_count_after_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> pos_reg == wavhv_pkg::HDR_LEN)
        else $error("Data words were counted before the header was complete.");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && stopped_reg |=> !m_valid)
        else $error("A result was issued for a word following an error.");
`endif

endmodule
